>>> hw/rtl/ctdg_pkg.sv
// Shared types, constants, scaling and counter functions of the clock tick drift and gap monitor.
package ctdg_pkg;

    // Width of the saturating escalation counters.
    localparam int CNT_W = 32;

    localparam logic [15:0] CONF_ONE     = 16'd32768;
    localparam logic [15:0] CONF_HALF    = 16'd16384;
    localparam logic [16:0] PHASE_STEP   = 17'd819;
    localparam logic [16:0] PHASE_TWO_PI = 17'd51472;
    localparam logic [62:0] DRIFT_MAX    = {63{1'b1}};

    // Reset values of the configuration registers.
    localparam logic [31:0] CADENCE_RST  = 32'd1000000;
    localparam logic [31:0] THRESH_RST   = 32'd100000;
    localparam logic [15:0] MIN_CONF_RST = 16'd16384;

    // Reciprocal multipliers: floor(c*4/5) = (c*209716) >> 18 and
    // floor(c*17/20) = (c*14260637) >> 24, exact for c up to 32768.
    localparam logic [17:0] GAP_MULT   = 18'd209716;
    localparam int          GAP_SHIFT  = 18;
    localparam logic [23:0] WARN_MULT  = 24'd14260637;
    localparam int          WARN_SHIFT = 24;

    // Bit positions in the flags field.
    localparam int FLAG_ALIGNED  = 0;
    localparam int FLAG_EXTERNAL = 1;
    localparam int FLAG_FALLBACK = 2;
    localparam int FLAG_GAP      = 3;
    localparam int FLAG_WARN     = 4;

    typedef enum logic [2:0] {
        CFG_CADENCE   = 3'd0,
        CFG_THRESH    = 3'd1,
        CFG_MIN_CONF  = 3'd2,
        CFG_STRESS_EN = 3'd3,
        CFG_META_EN   = 3'd4
    } t_cfg_idx;

    typedef enum logic {
        OP_INGEST  = 1'b0,
        OP_ADVANCE = 1'b1
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [63:0] index_in;
        logic [63:0] stamp_in;
        logic [15:0] phase_in;
        logic [15:0] confidence_in;
        logic [63:0] local_time;
    } t_item;

    typedef struct packed {
        logic [31:0] target_cadence;
        logic [31:0] drift_threshold;
        logic [15:0] min_confidence;
        logic        stress_enable;
        logic        meta_lock_enable;
    } t_cfg;

    typedef struct packed {
        logic [63:0]      last_stamp;
        logic [63:0]      last_index;
        logic [15:0]      last_phase;
        logic [62:0]      drift_peak;
        logic [CNT_W-1:0] stress_total;
        logic [CNT_W-1:0] meta_lock_total;
    } t_state;

    typedef struct packed {
        logic [63:0] index_out;
        logic [63:0] stamp_out;
        logic [63:0] drift_out;
        logic [15:0] phase_out;
        logic [15:0] confidence_out;
        logic [4:0]  flags;
        logic        degraded;
        logic        stress_raised;
        logic        meta_raised;
        logic [62:0] peak_drift;
        logic [31:0] stress_count;
        logic [31:0] meta_lock_count;
    } t_result;

    // Confidence times 0.8 after an index gap.
    function automatic logic [15:0] scale_gap(input logic [15:0] c);
        logic [33:0] prod;
        prod = 34'(c) * 34'(GAP_MULT);
        return 16'(prod >> GAP_SHIFT);
    endfunction

    // Confidence times 0.85 after a drift warning.
    function automatic logic [15:0] scale_warn(input logic [15:0] c);
        logic [39:0] prod;
        prod = 40'(c) * 40'(WARN_MULT);
        return 16'(prod >> WARN_SHIFT);
    endfunction

    // Saturating increment of an escalation counter.
    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
        return (c == {CNT_W{1'b1}}) ? c : c + 1'b1;
    endfunction

    // Low 32 bits of a counter, zero-extended when the counter is narrower.
    function automatic logic [31:0] count32(input logic [CNT_W-1:0] c);
        logic [63:0] ext;
        ext = 64'(c);
        return ext[31:0];
    endfunction

endpackage

>>> hw/rtl/ctdg_eval.sv
// Tick evaluation: drift, gap and confidence checks, escalations and fallback tick generation.
module ctdg_eval (
    input  ctdg_pkg::t_item   i_item,
    input  ctdg_pkg::t_cfg    i_cfg,
    input  ctdg_pkg::t_state  i_state,
    output ctdg_pkg::t_result o_result,
    output ctdg_pkg::t_state  o_state
);
    import ctdg_pkg::*;

    logic [15:0] conf_clamped;
    logic [63:0] elapsed;
    logic [63:0] cadence64;
    logic [63:0] excess;
    logic        measure;
    logic        neg;
    logic [62:0] drift_mag;
    logic [63:0] drift_bits;
    logic        gap;
    logic        warn;
    logic        conf_low;
    logic [15:0] conf_gap;
    logic [15:0] conf_final;
    logic        degraded;
    logic        esc_s;
    logic        esc_m;
    logic [62:0] peak_ext;
    logic [CNT_W-1:0] stress_ext;
    logic [CNT_W-1:0] meta_ext;
    logic [63:0] fb_index;
    logic [63:0] fb_stamp;
    logic [16:0] phase_sum;
    logic [16:0] phase_wrap;

    // External tick: drift against the stored stamp and cadence.
    always_comb begin
        conf_clamped = (i_item.confidence_in > CONF_ONE) ? CONF_ONE : i_item.confidence_in;
        cadence64    = {32'd0, i_cfg.target_cadence};
        elapsed      = i_item.stamp_in - i_state.last_stamp;
        excess       = elapsed - cadence64;
        measure      = (i_state.last_stamp != 64'd0) && (i_item.stamp_in > i_state.last_stamp);
        neg          = 1'b0;
        drift_mag    = '0;
        if (measure) begin
            if (elapsed >= cadence64) begin
                drift_mag = excess[63] ? DRIFT_MAX : excess[62:0];
            end else begin
                drift_mag = 63'(cadence64 - elapsed);
                neg       = 1'b1;
            end
        end
        drift_bits = neg ? (64'd0 - {1'b0, drift_mag}) : {1'b0, drift_mag};
    end

    // External tick: gap and warning checks, confidence scaling, escalations.
    always_comb begin
        gap = (i_state.last_index != 64'd0) && (i_state.last_index != {64{1'b1}})
              && (i_item.index_in > i_state.last_index + 64'd1);
        warn       = drift_mag > {31'd0, i_cfg.drift_threshold};
        conf_gap   = gap ? scale_gap(conf_clamped) : conf_clamped;
        conf_final = warn ? scale_warn(conf_gap) : conf_gap;
        conf_low   = conf_final < i_cfg.min_confidence;
        degraded   = gap || warn || conf_low;
        esc_s      = degraded && i_cfg.stress_enable && (conf_low || warn);
        esc_m      = degraded && i_cfg.meta_lock_enable
                     && ((conf_final < CONF_HALF)
                         || (drift_mag > {30'd0, i_cfg.drift_threshold, 1'b0}));
        peak_ext   = (drift_mag > i_state.drift_peak) ? drift_mag : i_state.drift_peak;
        stress_ext = esc_s ? bump(i_state.stress_total) : i_state.stress_total;
        meta_ext   = esc_m ? bump(i_state.meta_lock_total) : i_state.meta_lock_total;
    end

    // Fallback tick: index, stamp and phase advance from the stored values.
    always_comb begin
        fb_index   = i_state.last_index + 64'd1;
        fb_stamp   = (i_state.last_stamp != 64'd0)
                     ? i_state.last_stamp + {32'd0, i_cfg.target_cadence}
                     : i_item.local_time;
        phase_sum  = {1'b0, i_state.last_phase} + PHASE_STEP;
        phase_wrap = (phase_sum >= PHASE_TWO_PI) ? phase_sum - PHASE_TWO_PI : phase_sum;
    end

    // Select the result and the next state by operation.
    always_comb begin
        o_state  = i_state;
        o_result = '0;
        case (i_item.op)
            OP_INGEST: begin
                o_result.index_out      = i_item.index_in;
                o_result.stamp_out      = i_item.stamp_in;
                o_result.drift_out      = drift_bits;
                o_result.phase_out      = i_item.phase_in;
                o_result.confidence_out = conf_final;
                o_result.flags[FLAG_ALIGNED]  = 1'b1;
                o_result.flags[FLAG_EXTERNAL] = 1'b1;
                o_result.flags[FLAG_GAP]      = gap;
                o_result.flags[FLAG_WARN]     = warn;
                o_result.degraded       = degraded;
                o_result.stress_raised  = esc_s;
                o_result.meta_raised    = esc_m;
                o_state.last_index      = i_item.index_in;
                o_state.last_stamp      = i_item.stamp_in;
                o_state.last_phase      = i_item.phase_in;
                o_state.drift_peak      = peak_ext;
                o_state.stress_total    = stress_ext;
                o_state.meta_lock_total = meta_ext;
            end
            default: begin
                o_result.index_out      = fb_index;
                o_result.stamp_out      = fb_stamp;
                o_result.phase_out      = phase_wrap[15:0];
                o_result.confidence_out = CONF_ONE;
                o_result.flags[FLAG_ALIGNED]  = 1'b1;
                o_result.flags[FLAG_FALLBACK] = 1'b1;
                o_state.last_index = fb_index;
                o_state.last_stamp = fb_stamp;
                o_state.last_phase = phase_wrap[15:0];
            end
        endcase
        o_result.peak_drift      = o_state.drift_peak;
        o_result.stress_count    = count32(o_state.stress_total);
        o_result.meta_lock_count = count32(o_state.meta_lock_total);
    end

endmodule

>>> hw/rtl/clock_tick_drift_gap_monitor.sv
// Top level of the clock tick drift and gap monitor: input and result registers, state, config.
//
//  Channel   Direction  Handshake                    Payload
//  s_axis    in         s_axis_tvalid/s_axis_tready  tdata 224 bits, tuser op
//  m_axis    out        m_axis_tvalid/m_axis_tready  tdata 360 bits
//  cfg       in         i_cfg_wr_en                  i_cfg_index, i_cfg_data
//
// One request per cycle is taken while the receiver takes results; a request is registered in
// the input register, then one evaluation pass carries it into the result register, from which
// it can be taken. The evaluation pass also writes the tick state, so the next request sees it
// at once. Reset is synchronous and active low; it clears the valid flags and the tick state and
// sets the configuration registers to their defaults. A stalled result holds while one more
// request waits in the input register.
module clock_tick_drift_gap_monitor (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Fields from bit 0: index_in 64, stamp_in 64, phase_in 16, confidence_in 16,
    // local_time 64.
    input  logic [223:0] s_axis_tdata,
    // Fields from bit 0: op 1.
    input  logic [0:0]   s_axis_tuser,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // Fields from bit 0: index_out 64, stamp_out 64, drift_out 64, phase_out 16,
    // confidence_out 16, flags 5, degraded 1, stress_raised 1, meta_raised 1,
    // peak_drift 63, stress_count 32, meta_lock_count 32, one zero pad bit.
    output logic [359:0] m_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic         i_cfg_wr_en,
    input  logic [2:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data
);
    import ctdg_pkg::*;

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    t_state  r_state;
    t_cfg    r_cfg;
    t_result n_result;
    t_state  n_state;
    logic    w_adv;
    t_item   w_item;

    // A request moves into evaluation when the result register is free or draining.
    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;

    // Unpack the incoming request.
    always_comb begin
        w_item.op            = t_op'(s_axis_tuser[0]);
        w_item.index_in      = s_axis_tdata[63:0];
        w_item.stamp_in      = s_axis_tdata[127:64];
        w_item.phase_in      = s_axis_tdata[143:128];
        w_item.confidence_in = s_axis_tdata[159:144];
        w_item.local_time    = s_axis_tdata[223:160];
    end

    ctdg_eval u_eval (
        .i_item   (r_in),
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .o_result (n_result),
        .o_state  (n_state)
    );

    // Control, tick state and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid             <= 1'b0;
            r_out_valid            <= 1'b0;
            r_state                <= '0;
            r_cfg.target_cadence   <= CADENCE_RST;
            r_cfg.drift_threshold  <= THRESH_RST;
            r_cfg.min_confidence   <= MIN_CONF_RST;
            r_cfg.stress_enable    <= 1'b1;
            r_cfg.meta_lock_enable <= 1'b1;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    CFG_CADENCE:   r_cfg.target_cadence   <= i_cfg_data;
                    CFG_THRESH:    r_cfg.drift_threshold  <= i_cfg_data;
                    CFG_MIN_CONF:  r_cfg.min_confidence   <= i_cfg_data[15:0];
                    CFG_STRESS_EN: r_cfg.stress_enable    <= i_cfg_data[0];
                    CFG_META_EN:   r_cfg.meta_lock_enable <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in <= w_item;
        end
        if (w_adv) begin
            r_out <= n_result;
        end
    end

    // Pack the result.
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out.meta_lock_count, r_out.stress_count, r_out.peak_drift,
                            r_out.meta_raised, r_out.stress_raised, r_out.degraded,
                            r_out.flags, r_out.confidence_out, r_out.phase_out,
                            r_out.drift_out, r_out.stamp_out, r_out.index_out};

`ifndef ASSERT_OFF
    // The stress escalation counter never moves backward.
    a_stress_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n |=> (r_state.stress_total >= $past(r_state.stress_total)))
        else $error("stress counter decreased");

    // The peak drift never shrinks.
    a_peak_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n |=> (r_state.drift_peak >= $past(r_state.drift_peak)))
        else $error("peak drift decreased");

    // Tick state changes only when a request is evaluated.
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_state))
        else $error("tick state changed without a request");

    // A fallback result carries no drift and no escalation.
    a_fallback_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.flags[FLAG_FALLBACK]) |->
        (r_out.drift_out == 64'd0 && !r_out.stress_raised && !r_out.meta_raised))
        else $error("fallback result with drift or escalation");

    // Any escalation comes only from a degraded tick.
    a_esc_degraded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.stress_raised || r_out.meta_raised)) |->
        r_out.degraded)
        else $error("escalation on a tick that is not degraded");
`endif

endmodule

>>> tb/tb_clock_tick_drift_gap_monitor.sv
// Self-checking testbench for the clock tick drift and gap monitor, with directed and random ticks.
module tb_clock_tick_drift_gap_monitor;
    import ctdg_pkg::*;

    localparam int LIMIT_CYCLES = 150000;
    localparam int HOLD_CYCLES  = 60;

    localparam logic [4:0] FLAGS_EXT  = 5'((1 << FLAG_ALIGNED) | (1 << FLAG_EXTERNAL));
    localparam logic [4:0] FLAGS_FALL = 5'((1 << FLAG_ALIGNED) | (1 << FLAG_FALLBACK));

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_SKIP4,
        RX_COIN,
        RX_SPARSE
    } t_rx_mode;

    typedef struct {
        t_item   it;
        logic    pinned;
        t_result want;
    } t_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic [223:0] s_axis_tdata = '0;
    logic [0:0]   s_axis_tuser = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [359:0] m_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic         i_cfg_wr_en = 1'b0;
    logic [2:0]   i_cfg_index = '0;
    logic [31:0]  i_cfg_data = '0;

    // Predictor copy of the monitor's configuration and tick state.
    t_cfg    mon_cfg;
    t_state  mon_state;
    t_result pending_results[$];

    // Pinned result for the request currently offered.
    logic    pin_on = 1'b0;
    t_result pin_result = '0;

    // Stimulus trackers for well-formed tick sequences.
    logic [63:0] gen_idx = '0;
    logic [63:0] gen_stamp = '0;
    int          burst_left = 0;

    // Receiver stall control.
    logic [7:0] hold_tag = '0;
    logic [7:0] hold_seen = '0;
    int         hold_left = 0;
    logic [7:0] rx_cycle = '0;
    t_rx_mode   rx_mode = RX_OPEN;

    int fail_count = 0;
    int cycle_count = 0;

    t_row directed_rows[18];

    clock_tick_drift_gap_monitor dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Works out the result of one tick and advances the predicted state.
    function automatic t_result predict_tick(input t_item it);
        t_result     r;
        logic [63:0] elapsed;
        logic [63:0] dmag;
        logic [15:0] c;
        logic [32:0] twice;
        logic [16:0] ph;
        logic        neg;
        logic        gap;
        logic        warn;
        logic        low;
        r = '0;
        if (it.op == OP_INGEST) begin
            c = (it.confidence_in > CONF_ONE) ? CONF_ONE : it.confidence_in;
            dmag = '0;
            neg = 1'b0;
            r.flags = FLAGS_EXT;
            if (mon_state.last_stamp != 0 && it.stamp_in > mon_state.last_stamp) begin
                elapsed = it.stamp_in - mon_state.last_stamp;
                if (elapsed >= 64'(mon_cfg.target_cadence)) begin
                    dmag = elapsed - 64'(mon_cfg.target_cadence);
                    if (dmag[63]) begin
                        dmag = {1'b0, DRIFT_MAX};
                    end
                end else begin
                    dmag = 64'(mon_cfg.target_cadence) - elapsed;
                    neg = 1'b1;
                end
            end
            r.drift_out = neg ? (64'd0 - dmag) : dmag;
            if (dmag[62:0] > mon_state.drift_peak) begin
                mon_state.drift_peak = dmag[62:0];
            end
            // A stored index of zero or of all ones is excluded, so it never shows a gap.
            gap = mon_state.last_index != 0 && mon_state.last_index != '1 &&
                  it.index_in > mon_state.last_index + 64'd1;
            if (gap) begin
                r.flags[FLAG_GAP] = 1'b1;
                r.degraded = 1'b1;
                c = 16'((32'(c) * 32'd4) / 32'd5);
            end
            warn = dmag > 64'(mon_cfg.drift_threshold);
            if (warn) begin
                r.flags[FLAG_WARN] = 1'b1;
                r.degraded = 1'b1;
                c = 16'((32'(c) * 32'd17) / 32'd20);
            end
            low = c < mon_cfg.min_confidence;
            if (low) begin
                r.degraded = 1'b1;
            end
            twice = {mon_cfg.drift_threshold, 1'b0};
            if (r.degraded) begin
                if (mon_cfg.stress_enable && (low || warn)) begin
                    r.stress_raised = 1'b1;
                    if (mon_state.stress_total != '1) begin
                        mon_state.stress_total = mon_state.stress_total + 1'b1;
                    end
                end
                if (mon_cfg.meta_lock_enable && (c < CONF_HALF || dmag > 64'(twice))) begin
                    r.meta_raised = 1'b1;
                    if (mon_state.meta_lock_total != '1) begin
                        mon_state.meta_lock_total = mon_state.meta_lock_total + 1'b1;
                    end
                end
            end
            r.index_out = it.index_in;
            r.stamp_out = it.stamp_in;
            r.phase_out = it.phase_in;
            r.confidence_out = c;
        end else begin
            r.index_out = mon_state.last_index + 64'd1;
            r.stamp_out = (mon_state.last_stamp != 0) ?
                          mon_state.last_stamp + 64'(mon_cfg.target_cadence) : it.local_time;
            ph = 17'(mon_state.last_phase) + PHASE_STEP;
            if (ph >= PHASE_TWO_PI) begin
                ph = ph - PHASE_TWO_PI;
            end
            r.phase_out = ph[15:0];
            r.confidence_out = CONF_ONE;
            r.flags = FLAGS_FALL;
        end
        mon_state.last_index = r.index_out;
        mon_state.last_stamp = r.stamp_out;
        mon_state.last_phase = r.phase_out;
        r.peak_drift = mon_state.drift_peak;
        r.stress_count = 32'(mon_state.stress_total);
        r.meta_lock_count = 32'(mon_state.meta_lock_total);
        return r;
    endfunction

    function automatic t_item ingest_item(input logic [63:0] idx, input logic [63:0] stamp,
                                          input logic [15:0] phase, input logic [15:0] conf);
        t_item it;
        it.op = OP_INGEST;
        it.index_in = idx;
        it.stamp_in = stamp;
        it.phase_in = phase;
        it.confidence_in = conf;
        it.local_time = {$urandom, $urandom};
        return it;
    endfunction

    function automatic t_item advance_item(input logic [63:0] lt);
        t_item it;
        it = ingest_item({$urandom, $urandom}, {$urandom, $urandom}, 16'($urandom), 16'($urandom));
        it.op = OP_ADVANCE;
        it.local_time = lt;
        return it;
    endfunction

    // Mostly well-formed ticks near the cadence, some fallback ticks, the rest noise.
    function automatic t_item make_tick();
        t_item       it;
        logic [63:0] span;
        logic [63:0] bound;
        logic [63:0] jit;
        logic [15:0] conf;
        logic [15:0] phase;
        int          pick;
        pick = $urandom_range(0, 99);
        conf = ($urandom_range(0, 4) != 0) ? 16'($urandom_range(14000, 40000)) : 16'($urandom);
        phase = ($urandom_range(0, 7) != 0) ? 16'($urandom_range(0, 51471)) : 16'($urandom);
        if (pick < 15) begin
            it = advance_item({$urandom, $urandom});
            gen_idx = gen_idx + 64'd1;
            gen_stamp = (gen_stamp != 0) ? gen_stamp + 64'(mon_cfg.target_cadence) : it.local_time;
        end else if (pick < 80) begin
            span = 64'(mon_cfg.drift_threshold);
            case ($urandom_range(0, 3))
                0: bound = '0;
                1: bound = span >> 1;
                2: bound = span + (span >> 1);
                default: bound = span * 64'd3;
            endcase
            jit = (bound == 0) ? 64'd0 : {$urandom, $urandom} % (bound + 64'd1);
            gen_idx = gen_idx + 64'd1;
            if ($urandom_range(0, 7) == 0) begin
                gen_idx = gen_idx + 64'($urandom_range(1, 5));
            end
            gen_stamp = gen_stamp + 64'(mon_cfg.target_cadence);
            gen_stamp = $urandom_range(0, 1) ? gen_stamp + jit : gen_stamp - jit;
            it = ingest_item(gen_idx, gen_stamp, phase, conf);
        end else begin
            it = ingest_item({$urandom, $urandom}, {$urandom, $urandom}, phase, 16'($urandom));
            gen_idx = it.index_in;
            gen_stamp = it.stamp_in;
        end
        return it;
    endfunction

    function automatic logic [31:0] flag_word(input logic b);
        logic [31:0] w;
        w = $urandom;
        w[0] = b;
        return w;
    endfunction

    function automatic logic [31:0] conf_word(input logic [15:0] v);
        logic [31:0] w;
        w = $urandom;
        w[15:0] = v;
        return w;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endtask

    // Offers one request and returns at the edge where it is accepted.
    task automatic send_tick(input t_item it, input logic pin, input t_result pin_res);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {it.local_time, it.confidence_in, it.phase_in, it.stamp_in, it.index_in};
        s_axis_tuser <= it.op;
        pin_on = pin;
        pin_result = pin_res;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
    endtask

    // Bursts of back-to-back requests separated by short idle gaps.
    task automatic pace();
        if (burst_left != 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) :
                                                       $urandom_range(1, 12);
            repeat ($urandom_range(1, 6)) begin
                @(negedge i_clk);
                s_axis_tvalid <= 1'b0;
            end
        end
    endtask

    // Stops offering and waits until every pending result has come back.
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        case (t_cfg_idx'(idx))
            CFG_CADENCE:   mon_cfg.target_cadence = data;
            CFG_THRESH:    mon_cfg.drift_threshold = data;
            CFG_MIN_CONF:  mon_cfg.min_confidence = data[15:0];
            CFG_STRESS_EN: mon_cfg.stress_enable = data[0];
            CFG_META_EN:   mon_cfg.meta_lock_enable = data[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic write_all(input logic [31:0] cad, input logic [31:0] thr,
                             input logic [15:0] minc, input logic s_en, input logic m_en);
        write_reg(CFG_CADENCE, cad);
        write_reg(CFG_THRESH, thr);
        write_reg(CFG_MIN_CONF, conf_word(minc));
        write_reg(CFG_STRESS_EN, flag_word(s_en));
        write_reg(CFG_META_EN, flag_word(m_en));
    endtask

    task automatic run_random(input int count, input logic with_hold);
        t_item it;
        for (int k = 0; k < count; k++) begin
            it = make_tick();
            send_tick(it, 1'b0, '0);
            if (with_hold && k == count / 3) begin
                hold_tag <= hold_tag + 1'b1;
            end
            pace();
        end
    endtask

    // Receiver: a changing stall pattern, plus a long hold-off on request.
    always @(negedge i_clk) begin
        rx_cycle <= rx_cycle + 1'b1;
        if (hold_tag != hold_seen) begin
            hold_seen <= hold_tag;
            hold_left <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            if (rx_cycle[5:0] == 6'd0) begin
                rx_mode <= t_rx_mode'($urandom_range(0, 3));
            end
            case (rx_mode)
                RX_OPEN:   m_axis_tready <= 1'b1;
                RX_SKIP4:  m_axis_tready <= (rx_cycle[1:0] != 2'b11);
                RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_axis_tready <= ($urandom_range(0, 4) == 0);
                default:   m_axis_tready <= 1'b1;
            endcase
        end
    end

    // Each accepted request is predicted in order of acceptance.
    always @(posedge i_clk) begin : request_capture
        t_item   it;
        t_result r;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            it.op = t_op'(s_axis_tuser[0]);
            it.index_in = s_axis_tdata[63:0];
            it.stamp_in = s_axis_tdata[127:64];
            it.phase_in = s_axis_tdata[143:128];
            it.confidence_in = s_axis_tdata[159:144];
            it.local_time = s_axis_tdata[223:160];
            r = predict_tick(it);
            pending_results.push_back(pin_on ? pin_result : r);
        end
    end

    // Each accepted result is compared with the oldest pending one.
    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.index_out = m_axis_tdata[63:0];
            got.stamp_out = m_axis_tdata[127:64];
            got.drift_out = m_axis_tdata[191:128];
            got.phase_out = m_axis_tdata[207:192];
            got.confidence_out = m_axis_tdata[223:208];
            got.flags = m_axis_tdata[228:224];
            got.degraded = m_axis_tdata[229];
            got.stress_raised = m_axis_tdata[230];
            got.meta_raised = m_axis_tdata[231];
            got.peak_drift = m_axis_tdata[294:232];
            got.stress_count = m_axis_tdata[326:295];
            got.meta_lock_count = m_axis_tdata[358:327];
            if (pending_results.size() == 0) begin
                $error("result with no pending request: index_out %0h", got.index_out);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("index_out", want.index_out, got.index_out);
                check_field("stamp_out", want.stamp_out, got.stamp_out);
                check_field("drift_out", want.drift_out, got.drift_out);
                check_field("phase_out", 64'(want.phase_out), 64'(got.phase_out));
                check_field("confidence_out", 64'(want.confidence_out),
                            64'(got.confidence_out));
                check_field("flags", 64'(want.flags), 64'(got.flags));
                check_field("degraded", 64'(want.degraded), 64'(got.degraded));
                check_field("stress_raised", 64'(want.stress_raised),
                            64'(got.stress_raised));
                check_field("meta_raised", 64'(want.meta_raised),
                            64'(got.meta_raised));
                check_field("peak_drift", 64'(want.peak_drift), 64'(got.peak_drift));
                check_field("stress_count", 64'(want.stress_count), 64'(got.stress_count));
                check_field("meta_lock_count", 64'(want.meta_lock_count),
                            64'(got.meta_lock_count));
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("tb_clock_tick_drift_gap_monitor failed");
            $finish;
        end
    end

    initial begin
        mon_cfg = '{CADENCE_RST, THRESH_RST, MIN_CONF_RST, 1'b1, 1'b1};
        mon_state = '0;

        // Directed ticks; the first three rows carry results typed in by hand.
        directed_rows = '{
            // All-ones index and stamp right after reset, confidence clamped.
            '{ingest_item('1, '1, 16'd51471, 16'hFFFF), 1'b1,
              '{'1, '1, 64'd0, 16'd51471, CONF_ONE, FLAGS_EXT, 1'b0, 1'b0, 1'b0,
                63'd0, 32'd0, 32'd0}},
            // Fallback wraps the index and stamp and the phase past two pi.
            '{advance_item('1), 1'b1,
              '{64'd0, 64'd999999, 64'd0, 16'd818, CONF_ONE, FLAGS_FALL, 1'b0, 1'b0, 1'b0,
                63'd0, 32'd0, 32'd0}},
            // Zero confidence escalates both ways.
            '{ingest_item(64'd5, 64'd999999, 16'd0, 16'd0), 1'b1,
              '{64'd5, 64'd999999, 64'd0, 16'd0, 16'd0, FLAGS_EXT, 1'b1, 1'b1, 1'b1,
                63'd0, 32'd1, 32'd1}},
            '{ingest_item(64'd6, 64'd1999999, 16'd100, CONF_ONE), 1'b0, '0},
            '{ingest_item(64'd9, 64'd3149999, 16'd200, 16'd20000), 1'b0, '0},
            '{ingest_item(64'd10, 64'd3649999, 16'd300, CONF_ONE), 1'b0, '0},
            '{ingest_item(64'd11, 64'd3649999, 16'd400, CONF_HALF), 1'b0, '0},
            '{ingest_item(64'd12, '1, 16'd500, 16'd16383), 1'b0, '0},
            '{ingest_item(64'd13, 64'd0, 16'd600, 16'd30000), 1'b0, '0},
            '{advance_item(64'hA5A5_5A5A_0F0F_F0F0), 1'b0, '0},
            '{ingest_item('1, 64'd1, 16'hFFFF, 16'd32769), 1'b0, '0},
            '{ingest_item(64'd5, 64'd2, 16'd1, 16'd30000), 1'b0, '0},
            '{ingest_item(64'd6, 64'd1000002, 16'hFFFF, 16'd40000), 1'b0, '0},
            '{advance_item(64'd0), 1'b0, '0},
            '{ingest_item(64'd0, 64'd3000002, 16'd51471, 16'd32767), 1'b0, '0},
            '{ingest_item(64'd1000, 64'd3900002, 16'd8192, 16'd25000), 1'b0, '0},
            '{advance_item(64'd7), 1'b0, '0},
            '{advance_item(64'd8), 1'b0, '0}
        };

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k]) begin
            send_tick(directed_rows[k].it, directed_rows[k].pinned, directed_rows[k].want);
            pace();
        end
        run_random(110, 1'b1);

        // Zero cadence, zero threshold, no stress escalation.
        drain();
        write_all(32'd0, 32'd0, 16'd0, 1'b0, 1'b1);
        run_random(90, 1'b0);

        // Largest cadence and threshold, full minimum confidence.
        drain();
        write_all('1, '1, CONF_ONE, 1'b1, 1'b0);
        run_random(90, 1'b0);

        // Random setting, plus writes to indexes past the last register.
        drain();
        write_all($urandom, 32'($urandom_range(0, 1 << 20)), 16'($urandom_range(0, 32768)),
                  1'b1, 1'b1);
        for (int k = int'(CFG_META_EN) + 1; k < (1 << $bits(i_cfg_index)); k++) begin
            write_reg(3'(k), $urandom);
        end
        run_random(90, 1'b0);

        // Back to the reset setting.
        drain();
        write_all(CADENCE_RST, THRESH_RST, MIN_CONF_RST, 1'b1, 1'b1);
        run_random(110, 1'b1);

        drain();
        if (fail_count == 0) begin
            $display("tb_clock_tick_drift_gap_monitor passed");
        end else begin
            $display("tb_clock_tick_drift_gap_monitor failed");
        end
        $finish;
    end

endmodule
